// File: rtl/assert_macros.svh
// Assertion macros for the console command tokenizer checker.
// Depends on nothing; included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CCT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define CCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cct_pkg.sv
// Package for the console command tokenizer: item types, codes, keyword table.
// No dependencies.
`default_nettype none
package cct_pkg;

	localparam logic OP_FEED  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] ZERO_CHAR  = 8'h00;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	localparam logic [3:0] CODE_EMPTY   = 4'd0;
	localparam logic [3:0] CODE_INVALID = 4'd8;

	localparam int NUM_KW  = 7;
	localparam int MAX_OUT = 64;
	localparam int NW      = $clog2(MAX_OUT + 1);

	typedef enum logic [1:0] {
		PH_WAIT_CMD,
		PH_READ_CMD,
		PH_WAIT_ARG,
		PH_READ_ARG
	} parse_phase_t;

	typedef enum logic {
		B_IDLE,
		B_SCAN
	} back_state_t;

	typedef struct packed {
		logic       is_fetch;
		logic [7:0] ch;
		logic       is_space;
		logic       eol;
		logic [5:0] start;
		logic [6:0] limit;
	} item_t;

	typedef struct packed {
		logic [3:0] cmd_code;
		logic [7:0] arg_char;
		logic       char_valid;
		logic       char_kept;
		logic [6:0] token_length;
		logic       last;
	} result_t;

	function automatic logic [3:0] kw_len(input logic [2:0] k);
		logic [3:0] len;
		case (k)
			3'd0: len = 4'd4;
			3'd1: len = 4'd5;
			3'd2: len = 4'd8;
			3'd3: len = 4'd3;
			3'd4: len = 4'd2;
			3'd5: len = 4'd5;
			3'd6: len = 4'd5;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [63:0] w;
		case (k)
			3'd0: w = {"help", 32'd0};
			3'd1: w = {"reset", 24'd0};
			3'd2: w = "initcard";
			3'd3: w = {"dir", 40'd0};
			3'd4: w = {"cd", 48'd0};
			3'd5: w = {"flash", 24'd0};
			3'd6: w = {"erase", 24'd0};
			default: w = 64'd0;
		endcase
		return w[8 * (7 - int'(p)) +: 8];
	endfunction

endpackage
`default_nettype wire

// File: rtl/cct_front.sv
// Front part: accepts transactions, lower-cases and classifies them, and
// queues them for the back part. Depends on cct_pkg.
`default_nettype none
module cct_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           opcode,
	input  wire logic [7:0]     char_in,
	input  wire logic           end_of_line,
	input  wire logic [5:0]     start_index,
	input  wire logic [6:0]     limit,
	output logic                q_valid,
	output cct_pkg::item_t      q_head,
	input  wire logic           q_pop
);

	cct_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	cct_pkg::item_t item;
	logic [7:0]     low_ch;

	always_comb begin
		if (char_in >= "A" && char_in <= "Z") begin
			low_ch = char_in + cct_pkg::CASE_DELTA;
		end else begin
			low_ch = char_in;
		end
		item.is_fetch = (opcode == cct_pkg::OP_FETCH);
		item.ch       = low_ch;
		item.is_space = (char_in == cct_pkg::SPACE_CHAR);
		item.eol      = end_of_line;
		item.start    = start_index;
		item.limit    = limit;
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/cct_back.sv
// Back part: line parser with incremental keyword match, argument store and
// token fetch scanner, with the output register. Depends on cct_pkg.
`default_nettype none
module cct_back #(
	parameter int CMD_DEPTH = 16,
	parameter int ARG_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire cct_pkg::item_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output cct_pkg::result_t    out_res
);

	localparam int AW  = $clog2(ARG_DEPTH);
	localparam int ACW = $clog2(ARG_DEPTH + 1);
	localparam int CCW = $clog2(CMD_DEPTH + 1);
	localparam int IW  = (ACW > 7) ? ACW : 7;
	localparam int NW  = cct_pkg::NW;

	cct_pkg::parse_phase_t phase_q, phase_nx;
	logic [CCW-1:0]        cmd_cnt_q, cmd_cnt_nx, cmd_base;
	logic [cct_pkg::NUM_KW-1:0] match_q, match_nx, match_base;
	logic [ACW-1:0]        arg_cnt_q, arg_cnt_nx;
	logic [7:0]            arg_mem [ARG_DEPTH];
	logic [7:0]            rd_data_q;
	logic                  arg_we;

	cct_pkg::back_state_t  state_q, state_nx;
	logic [IW-1:0]         idx_q, idx_nx;
	logic [IW-1:0]         tok_len_q;
	logic                  found_q;
	logic                  pend_valid_q;
	logic [7:0]            pend_char_q;
	logic                  pend_kept_q;
	logic [NW-1:0]         sent_q;
	logic [6:0]            limit_q;

	cct_pkg::result_t      out_q, out_nx;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  out_load;

	logic                  feed_go;
	logic                  fetch_go;
	logic                  push_cmd;
	logic                  push_arg;
	logic [3:0]            code;

	logic                  at_end;
	logic                  tok;
	logic                  finish;
	logic                  need_emit;
	logic                  advance;
	logic                  cur_kept;

	assign out_free = !out_valid_q || !out_stall;
	assign feed_go  = (state_q == cct_pkg::B_IDLE) && q_valid && !q_head.is_fetch
		&& (!q_head.eol || out_free);
	assign fetch_go = (state_q == cct_pkg::B_IDLE) && q_valid && q_head.is_fetch;
	assign q_pop    = feed_go || fetch_go;

	// line parser
	always_comb begin
		phase_nx   = phase_q;
		arg_cnt_nx = arg_cnt_q;
		push_cmd   = 1'b0;
		push_arg   = 1'b0;
		cmd_base   = cmd_cnt_q;
		match_base = match_q;
		case (phase_q)
			cct_pkg::PH_WAIT_CMD: begin
				arg_cnt_nx = '0;
				cmd_base   = '0;
				match_base = '1;
				if (!q_head.is_space) begin
					phase_nx = cct_pkg::PH_READ_CMD;
					push_cmd = 1'b1;
				end
			end
			cct_pkg::PH_READ_CMD: begin
				if (!q_head.is_space) begin
					push_cmd = 1'b1;
				end else begin
					phase_nx = cct_pkg::PH_WAIT_ARG;
				end
			end
			cct_pkg::PH_WAIT_ARG: begin
				if (!q_head.is_space) begin
					phase_nx = cct_pkg::PH_READ_ARG;
					push_arg = 1'b1;
				end
			end
			default: begin
				push_arg = 1'b1;
			end
		endcase

		cmd_cnt_nx = cmd_base;
		match_nx   = match_base;
		if (push_cmd && cmd_base < CCW'(CMD_DEPTH)) begin
			cmd_cnt_nx = cmd_base + CCW'(1);
			for (int k = 0; k < cct_pkg::NUM_KW; k++) begin
				match_nx[k] = match_base[k]
					&& (cmd_base < CCW'(cct_pkg::kw_len(3'(k))))
					&& (q_head.ch == cct_pkg::kw_char(3'(k), cmd_base[2:0]));
			end
		end

		arg_we = 1'b0;
		if (push_arg && arg_cnt_q < ACW'(ARG_DEPTH)) begin
			arg_we     = 1'b1;
			arg_cnt_nx = arg_cnt_q + ACW'(1);
		end

		code = cct_pkg::CODE_INVALID;
		for (int k = cct_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (match_nx[k] && cmd_cnt_nx == CCW'(cct_pkg::kw_len(3'(k)))) begin
				code = 4'(k + 1);
			end
		end
		if (cmd_cnt_nx == '0) begin
			code = cct_pkg::CODE_EMPTY;
		end
	end

	// scanner decisions
	always_comb begin
		at_end    = (idx_q >= IW'(arg_cnt_q));
		tok       = (rd_data_q != cct_pkg::SPACE_CHAR) && (rd_data_q != cct_pkg::ZERO_CHAR);
		finish    = at_end || (found_q && !tok);
		need_emit = pend_valid_q && (sent_q < NW'(cct_pkg::MAX_OUT - 1));
		cur_kept  = (tok_len_q < IW'(limit_q));
		advance   = 1'b0;
		if (state_q == cct_pkg::B_SCAN && !finish) begin
			advance = !tok || !need_emit || out_free;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			cct_pkg::B_IDLE: begin
				if (fetch_go) begin
					state_nx = cct_pkg::B_SCAN;
				end
			end
			cct_pkg::B_SCAN: begin
				if (finish && out_free) begin
					state_nx = cct_pkg::B_IDLE;
				end
			end
			default: state_nx = cct_pkg::B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		out_load = 1'b0;
		out_nx   = '0;
		idx_nx   = idx_q;
		case (state_q)
			cct_pkg::B_IDLE: begin
				if (feed_go && q_head.eol) begin
					out_load        = 1'b1;
					out_nx.cmd_code = code;
					out_nx.last     = 1'b1;
				end
				if (fetch_go) begin
					idx_nx = IW'(q_head.start);
				end
			end
			cct_pkg::B_SCAN: begin
				if (finish) begin
					out_load    = out_free;
					out_nx.last = 1'b1;
					if (pend_valid_q) begin
						out_nx.arg_char     = pend_char_q;
						out_nx.char_valid   = 1'b1;
						out_nx.char_kept    = pend_kept_q;
						out_nx.token_length = 7'(tok_len_q);
					end
				end else if (advance) begin
					idx_nx = idx_q + IW'(1);
					if (tok && need_emit) begin
						out_load          = 1'b1;
						out_nx.arg_char   = pend_char_q;
						out_nx.char_valid = 1'b1;
						out_nx.char_kept  = pend_kept_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (feed_go && arg_we) begin
			arg_mem[arg_cnt_q[AW-1:0]] <= q_head.ch;
		end
		rd_data_q <= arg_mem[idx_nx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cct_pkg::PH_WAIT_CMD;
			cmd_cnt_q    <= '0;
			match_q      <= '1;
			arg_cnt_q    <= '0;
			state_q      <= cct_pkg::B_IDLE;
			idx_q        <= '0;
			tok_len_q    <= '0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			sent_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
			if (feed_go) begin
				arg_cnt_q <= arg_cnt_nx;
				match_q   <= match_nx;
				if (q_head.eol) begin
					phase_q   <= cct_pkg::PH_WAIT_CMD;
					cmd_cnt_q <= '0;
				end else begin
					phase_q   <= phase_nx;
					cmd_cnt_q <= cmd_cnt_nx;
				end
			end
			if (fetch_go) begin
				tok_len_q    <= '0;
				found_q      <= 1'b0;
				pend_valid_q <= 1'b0;
				sent_q       <= '0;
			end else if (advance && tok) begin
				tok_len_q <= tok_len_q + IW'(1);
				found_q   <= 1'b1;
				if (!pend_valid_q) begin
					pend_valid_q <= 1'b1;
				end else if (need_emit) begin
					sent_q <= sent_q + NW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_go) begin
			limit_q <= q_head.limit;
		end
		if (advance && tok && (!pend_valid_q || need_emit)) begin
			pend_char_q <= rd_data_q;
			pend_kept_q <= cur_kept;
		end
		if (out_load) begin
			out_q <= out_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

// File: rtl/console_command_tokenizer.sv
// Top level of the console command tokenizer: front classifier/queue and back
// executor. Depends on cct_pkg, cct_front, cct_back.
//
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | opcode char_in end_of_line start_index limit
// out     | output    | out_valid/out_stall | cmd_code arg_char char_valid char_kept
//         |           |                     | token_length last
//
// A feed transaction is handled by the back part once it reaches the queue head and the back part is idle.
// A fetch scans argument store entries from start_index to the token end,
// reading them through the registered read port of the argument store.
// The two-entry queue lets the front accept while the back works or is stalled.
// Reset clears parse state, counts, queue and output valid; stores need no clear.
// out_stall holds the output register; the back part waits when it must emit.
`default_nettype none
module console_command_tokenizer #(
	parameter int CMD_DEPTH = 16,
	parameter int ARG_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] char_in,
	input  wire logic       end_of_line,
	input  wire logic [5:0] start_index,
	input  wire logic [6:0] limit,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      cmd_code,
	output logic [7:0]      arg_char,
	output logic            char_valid,
	output logic            char_kept,
	output logic [6:0]      token_length,
	output logic            last
);

	logic             q_valid;
	logic             q_pop;
	cct_pkg::item_t   q_head;
	cct_pkg::result_t res;

	cct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.start_index (start_index),
		.limit       (limit),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	cct_back #(
		.CMD_DEPTH (CMD_DEPTH),
		.ARG_DEPTH (ARG_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign cmd_code     = res.cmd_code;
	assign arg_char     = res.arg_char;
	assign char_valid   = res.char_valid;
	assign char_kept    = res.char_kept;
	assign token_length = res.token_length;
	assign last         = res.last;

endmodule
`default_nettype wire

// File: rtl/cct_checker.sv
// Port-level checker for the console command tokenizer, bound to the top level.
// Depends on cct_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module cct_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       opcode,
	input wire logic [7:0] char_in,
	input wire logic       end_of_line,
	input wire logic [5:0] start_index,
	input wire logic [6:0] limit,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] cmd_code,
	input wire logic [7:0] arg_char,
	input wire logic       char_valid,
	input wire logic       char_kept,
	input wire logic [6:0] token_length,
	input wire logic       last
);

	logic [21:0] payload;
	logic        out_hold;
	logic        empty_ok;
	logic        mid_ok;
	logic        code_ok;

	assign payload  = {cmd_code, arg_char, char_valid, char_kept, token_length, last};
	assign out_hold = out_valid && out_stall;
	assign empty_ok = !out_valid || char_valid || (arg_char == 8'd0 && !char_kept && last);
	assign mid_ok   = !out_valid || last
		|| (char_valid && cmd_code == cct_pkg::CODE_EMPTY && token_length == 7'd0);
	assign code_ok  = !out_valid || (cmd_code <= cct_pkg::CODE_INVALID
		&& (cmd_code == cct_pkg::CODE_EMPTY || !char_valid));

	`CCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hold, out_valid && $stable(payload), "hold broken")
	`CCT_ASSERT(a_empty_token, clk, arst_n, empty_ok, "empty result malformed")
	`CCT_ASSERT(a_mid_token, clk, arst_n, mid_ok, "non-final result malformed")
	`CCT_ASSERT(a_code_range, clk, arst_n, code_ok, "line code out of range")

endmodule

bind console_command_tokenizer cct_checker u_cct_checker (.*);
`default_nettype wire
